/* hw/rtl/hbss_pkg.sv */
package hbss_pkg;

  // Default number of slots in each id table
  localparam int unsigned TableSlotsDef = 128;
  localparam int unsigned IdW           = 32;
  localparam int unsigned CntOutW       = 7;

  typedef enum logic [1:0] {
    CMD_SCHED   = 2'd0,
    CMD_DESCHED = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_ID    = 2'd1,
    ST_SCHED_FULL = 2'd2,
    ST_BLK_FULL   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_HOME_WAIT,
    S_SB_RD,
    S_SB_CHK,
    S_PL_RD,
    S_PL_CHK,
    S_DR_RD,
    S_DR_CHK,
    S_CL_SET,
    S_CL_RD,
    S_CL_CHK,
    S_CL_HOME,
    S_CL_NEXT,
    S_BLK,
    S_BLK_HOME,
    S_RESP,
    S_TK_EMPTY,
    S_TK_RD,
    S_TK_CHK
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    cap;
    logic    home_start;
    logic    ptr_home;
    logic    ptr_zero;
    logic    ptr_adv;
    logic    ptr_from_j;
    logic    j_from_ptr;
    logic    j_inc;
    logic    rd;
    logic    tsel_we;
    logic    tsel_blk;
    logic    wr_key;
    logic    clr_slot;
    logic    key_from_rd;
    logic    key_from_id;
    logic    st_we;
    status_e st_val;
    logic    emit_resp;
    logic    emit_tick;
    logic    k_clr;
    logic    k_inc;
    logic    clear_all;
  } ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_e cmd;
    logic id_zero;
    logic hit;
    logic empty;
    logic sched_full;
    logic blk_full;
    logic sched_empty;
    logic last_k;
    logic home_done;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/hbss_mod.sv */
module hbss_mod #(
  parameter int unsigned Slots = hbss_pkg::TableSlotsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [hbss_pkg::IdW-1:0] key_i,
  output logic                     done_o,
  output logic [$clog2(Slots)-1:0] rem_o
);
  import hbss_pkg::*;

  localparam int unsigned AW   = $clog2(Slots);
  localparam bit          Pow2 = ((Slots & (Slots - 1)) == 0);

  if (Pow2) begin : g_mask
    // Home slot is the low bits of the id
    assign rem_o  = key_i[AW-1:0];
    assign done_o = 1'b1;
  end else begin : g_recip
    // Remainder by reciprocal multiplication: low and high partial products,
    // then quotient times slots subtracted from the id
    localparam int unsigned Shift   = IdW + AW;
    localparam logic [63:0] Recip   =
      ((64'd1 << Shift) + 64'(Slots) - 64'd1) / 64'(Slots);
    localparam logic [15:0] RecipLo = Recip[15:0];
    localparam logic [16:0] RecipHi = Recip[32:16];

    logic [1:0]     phase_q;
    logic [IdW-1:0] x_q;
    logic [64:0]    acc_q;
    logic [AW-1:0]  r_q;
    logic [47:0]    plo_w;
    logic [48:0]    phi_w;
    logic [IdW-1:0] quo_w;
    logic [IdW-1:0] qm_w;

    assign plo_w = 48'(x_q) * 48'(RecipLo);
    assign phi_w = 49'(x_q) * 49'(RecipHi);
    assign quo_w = IdW'(acc_q >> Shift);
    assign qm_w  = quo_w * IdW'(Slots);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q <= 2'd0;
      end else if (start_i) begin
        phase_q <= 2'd1;
      end else if (phase_q != 2'd0) begin
        phase_q <= phase_q + 2'd1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        x_q <= key_i;
      end
      case (phase_q)
        2'd1:    acc_q <= 65'(plo_w);
        2'd2:    acc_q <= acc_q + {phi_w, 16'b0};
        2'd3:    r_q   <= AW'(x_q - qm_w);
        default: ;
      endcase
    end

    assign done_o = (phase_q == 2'd0);
    assign rem_o  = r_q;
  end

endmodule

/* hw/rtl/hbss_dp.sv */
module hbss_dp #(
  parameter int unsigned Slots = hbss_pkg::TableSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hbss_pkg::ctrl_t              ctrl_i,
  output hbss_pkg::stat_t              stat_o,
  input  logic [1:0]                   command_i,
  input  logic [hbss_pkg::IdW-1:0]     sender_id_i,
  input  logic                         cfg_we_i,
  input  logic [hbss_pkg::IdW-1:0]     cfg_data_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [hbss_pkg::IdW-1:0]     receiver_id_out_o,
  output logic [hbss_pkg::CntOutW-1:0] sender_count_o,
  output logic [hbss_pkg::IdW-1:0]     reported_sender_o,
  output logic                         last_o
);
  import hbss_pkg::*;

  localparam int unsigned AW = $clog2(Slots);
  localparam int unsigned CW = $clog2(Slots / 2 + 1);
  localparam logic [CW-1:0] Limit    = CW'(Slots / 2);
  localparam logic [AW-1:0] LastSlot = AW'(Slots - 1);

  cmd_e            cmd_q;
  status_e         st_q;
  logic [IdW-1:0]  id_q, key_q, rid_q, rds_q, rdb_q, rd_w;
  logic            tsel_q, rv_q;
  logic [AW-1:0]   ptr_q, j_q, home_w;
  logic [CW-1:0]   scnt_q, bcnt_q, k_q;
  logic [Slots-1:0] sval_q, bval_q;
  logic [IdW-1:0]  sched_mem [Slots];
  logic [IdW-1:0]  blk_mem   [Slots];
  logic            home_done_w;

  logic            out_valid_q, last_q;
  status_e         ost_q;
  logic [IdW-1:0]  orid_q, osnd_q;
  logic [CntOutW-1:0] ocnt_q;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == LastSlot) ? '0 : p + AW'(1);
  endfunction

  // Home slot unit
  hbss_mod #(.Slots(Slots)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.home_start),
    .key_i   (key_q),
    .done_o  (home_done_w),
    .rem_o   (home_w)
  );

  assign rd_w = tsel_q ? rdb_q : rds_q;

  // Item, key and pointer registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      cmd_q <= cmd_e'(command_i);
      id_q  <= sender_id_i;
      key_q <= sender_id_i;
    end else if (ctrl_i.key_from_rd) begin
      key_q <= rd_w;
    end else if (ctrl_i.key_from_id) begin
      key_q <= id_q;
    end
    if (ctrl_i.tsel_we) begin
      tsel_q <= ctrl_i.tsel_blk;
    end
    if (ctrl_i.ptr_home) begin
      ptr_q <= home_w;
    end else if (ctrl_i.ptr_zero) begin
      ptr_q <= '0;
    end else if (ctrl_i.ptr_adv) begin
      ptr_q <= next_slot(ptr_q);
    end else if (ctrl_i.ptr_from_j) begin
      ptr_q <= j_q;
    end
    if (ctrl_i.j_from_ptr) begin
      j_q <= next_slot(ptr_q);
    end else if (ctrl_i.j_inc) begin
      j_q <= next_slot(j_q);
    end
    if (ctrl_i.k_clr) begin
      k_q <= '0;
    end else if (ctrl_i.k_inc) begin
      k_q <= k_q + CW'(1);
    end
    if (ctrl_i.cap) begin
      st_q <= ST_OK;
    end else if (ctrl_i.st_we) begin
      st_q <= ctrl_i.st_val;
    end
  end

  // Table reads, registered
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rds_q <= sched_mem[ptr_q];
      rdb_q <= blk_mem[ptr_q];
      rv_q  <= tsel_q ? bval_q[ptr_q] : sval_q[ptr_q];
    end
  end

  // Table writes
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_key && !tsel_q) begin
      sched_mem[ptr_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_key && tsel_q) begin
      blk_mem[ptr_q] <= key_q;
    end
  end

  // Occupancy bits and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sval_q <= '0;
      bval_q <= '0;
      scnt_q <= '0;
      bcnt_q <= '0;
    end else if (ctrl_i.clear_all) begin
      sval_q <= '0;
      bval_q <= '0;
      scnt_q <= '0;
      bcnt_q <= '0;
    end else if (ctrl_i.wr_key) begin
      if (tsel_q) begin
        bval_q[ptr_q] <= 1'b1;
        bcnt_q        <= bcnt_q + CW'(1);
      end else begin
        sval_q[ptr_q] <= 1'b1;
        scnt_q        <= scnt_q + CW'(1);
      end
    end else if (ctrl_i.clr_slot) begin
      sval_q[ptr_q] <= 1'b0;
      scnt_q        <= scnt_q - CW'(1);
    end
  end

  // Receiver id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rid_q <= '0;
    end else if (cfg_we_i) begin
      rid_q <= cfg_data_i;
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit_resp || ctrl_i.emit_tick) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_resp) begin
      ost_q  <= st_q;
      orid_q <= '0;
      ocnt_q <= '0;
      osnd_q <= '0;
      last_q <= 1'b1;
    end else if (ctrl_i.emit_tick) begin
      ost_q  <= ST_OK;
      orid_q <= rid_q;
      ocnt_q <= CntOutW'(scnt_q);
      osnd_q <= (scnt_q == '0) ? '0 : rd_w;
      last_q <= (scnt_q == '0) ? 1'b1 : stat_o.last_k;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = ost_q;
  assign receiver_id_out_o = orid_q;
  assign sender_count_o    = ocnt_q;
  assign reported_sender_o = osnd_q;
  assign last_o            = last_q;

  // Status to controller
  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.id_zero     = (id_q == '0);
    stat_o.hit         = rv_q && (rd_w == key_q);
    stat_o.empty       = !rv_q;
    stat_o.sched_full  = (scnt_q >= Limit);
    stat_o.blk_full    = (bcnt_q >= Limit);
    stat_o.sched_empty = (scnt_q == '0);
    stat_o.last_k      = (({1'b0, k_q} + (CW+1)'(1)) == {1'b0, scnt_q});
    stat_o.home_done   = home_done_w;
    stat_o.out_free    = !out_valid_q || !out_stall_i;
  end

endmodule

/* hw/rtl/hbss_ctrl.sv */
module hbss_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  hbss_pkg::stat_t stat_i,
  output hbss_pkg::ctrl_t ctrl_o,
  output logic            in_stall_o
);
  import hbss_pkg::*;

  state_e state_q, state_d;
  state_e after_q, after_d;   // where to go once the home slot is known
  state_e plret_q, plret_d;   // where to go once a placement is done

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      after_q <= S_IDLE;
      plret_q <= S_IDLE;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      plret_q <= plret_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    after_d = after_q;
    plret_d = plret_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cap = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.cmd)
          CMD_SCHED, CMD_DESCHED: begin
            if (stat_i.id_zero) begin
              ctrl_o.st_we  = 1'b1;
              ctrl_o.st_val = ST_ZERO_ID;
              state_d       = S_RESP;
            end else begin
              ctrl_o.tsel_we    = 1'b1;
              ctrl_o.tsel_blk   = (stat_i.cmd == CMD_SCHED);
              ctrl_o.home_start = 1'b1;
              after_d           = (stat_i.cmd == CMD_SCHED) ? S_SB_RD : S_DR_RD;
              state_d           = S_HOME_WAIT;
            end
          end
          CMD_TICK: begin
            ctrl_o.tsel_we  = 1'b1;
            ctrl_o.tsel_blk = 1'b0;
            ctrl_o.ptr_zero = 1'b1;
            ctrl_o.k_clr    = 1'b1;
            state_d         = stat_i.sched_empty ? S_TK_EMPTY : S_TK_RD;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_HOME_WAIT: begin
        if (stat_i.home_done) begin
          ctrl_o.ptr_home = 1'b1;
          state_d         = after_q;
        end
      end
      // Lookup in the blocked set
      S_SB_RD: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_SB_CHK;
      end
      S_SB_CHK: begin
        if (stat_i.hit) begin
          state_d = S_RESP;
        end else if (stat_i.empty) begin
          if (stat_i.sched_full) begin
            ctrl_o.st_we  = 1'b1;
            ctrl_o.st_val = ST_SCHED_FULL;
            state_d       = S_RESP;
          end else begin
            ctrl_o.tsel_we    = 1'b1;
            ctrl_o.tsel_blk   = 1'b0;
            ctrl_o.home_start = 1'b1;
            after_d           = S_PL_RD;
            plret_d           = S_RESP;
            state_d           = S_HOME_WAIT;
          end
        end else begin
          ctrl_o.ptr_adv = 1'b1;
          state_d        = S_SB_RD;
        end
      end
      // Placement probe
      S_PL_RD: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_PL_CHK;
      end
      S_PL_CHK: begin
        if (stat_i.empty) begin
          ctrl_o.wr_key = 1'b1;
          state_d       = plret_q;
        end else if (stat_i.hit) begin
          state_d = plret_q;
        end else begin
          ctrl_o.ptr_adv = 1'b1;
          state_d        = S_PL_RD;
        end
      end
      // Removal probe in the scheduled set
      S_DR_RD: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_DR_CHK;
      end
      S_DR_CHK: begin
        if (stat_i.empty) begin
          state_d = S_BLK;
        end else if (stat_i.hit) begin
          ctrl_o.clr_slot   = 1'b1;
          ctrl_o.j_from_ptr = 1'b1;
          state_d           = S_CL_SET;
        end else begin
          ctrl_o.ptr_adv = 1'b1;
          state_d        = S_DR_RD;
        end
      end
      // Re-insert the rest of the cluster
      S_CL_SET: begin
        ctrl_o.ptr_from_j = 1'b1;
        state_d           = S_CL_RD;
      end
      S_CL_RD: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_CL_CHK;
      end
      S_CL_CHK: begin
        if (stat_i.empty) begin
          state_d = S_BLK;
        end else begin
          ctrl_o.key_from_rd = 1'b1;
          ctrl_o.clr_slot    = 1'b1;
          state_d            = S_CL_HOME;
        end
      end
      S_CL_HOME: begin
        ctrl_o.home_start = 1'b1;
        after_d           = S_PL_RD;
        plret_d           = S_CL_NEXT;
        state_d           = S_HOME_WAIT;
      end
      S_CL_NEXT: begin
        ctrl_o.j_inc = 1'b1;
        state_d      = S_CL_SET;
      end
      // Add to the blocked set
      S_BLK: begin
        ctrl_o.key_from_id = 1'b1;
        ctrl_o.tsel_we     = 1'b1;
        ctrl_o.tsel_blk    = 1'b1;
        if (stat_i.blk_full) begin
          ctrl_o.st_we  = 1'b1;
          ctrl_o.st_val = ST_BLK_FULL;
          state_d       = S_RESP;
        end else begin
          state_d = S_BLK_HOME;
        end
      end
      S_BLK_HOME: begin
        ctrl_o.home_start = 1'b1;
        after_d           = S_PL_RD;
        plret_d           = S_RESP;
        state_d           = S_HOME_WAIT;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_resp = 1'b1;
          state_d          = S_IDLE;
        end
      end
      // Heartbeat
      S_TK_EMPTY: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_tick = 1'b1;
          ctrl_o.clear_all = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_TK_RD: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_TK_CHK;
      end
      S_TK_CHK: begin
        if (stat_i.empty) begin
          ctrl_o.ptr_adv = 1'b1;
          state_d        = S_TK_RD;
        end else if (stat_i.out_free) begin
          ctrl_o.emit_tick = 1'b1;
          if (stat_i.last_k) begin
            ctrl_o.clear_all = 1'b1;
            state_d          = S_IDLE;
          end else begin
            ctrl_o.k_inc   = 1'b1;
            ctrl_o.ptr_adv = 1'b1;
            state_d        = S_TK_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/heartbeat_sender_set_engine.sv */
// Schedule/deschedule: a read and a check per probed slot plus a home-slot lookup
//   (the low id bits when TABLE_SLOTS is a power of two, a reciprocal remainder otherwise).
// Tick: a read and a check per slot, up to the last scheduled id, one word per id.
// One word in flight at a time; the output register lets the next word enter early.
// Reset (async, active low) clears the FSM, occupancy bits, counts and receiver id;
//   table contents are masked by the occupancy bits, so no clearing pass is run.
module heartbeat_sender_set_engine #(
  parameter int unsigned TABLE_SLOTS = hbss_pkg::TableSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [hbss_pkg::IdW-1:0]     sender_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [hbss_pkg::IdW-1:0]     receiver_id_out_o,
  output logic [hbss_pkg::CntOutW-1:0] sender_count_o,
  output logic [hbss_pkg::IdW-1:0]     reported_sender_o,
  output logic                         last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hbss_pkg::IdW-1:0]     cfg_data_i
);
  import hbss_pkg::*;

  ctrl_t ctrl_w;
  stat_t stat_w;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;

  hbss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat_w),
    .ctrl_o     (ctrl_w),
    .in_stall_o (in_stall_o)
  );

  hbss_dp #(.Slots(TABLE_SLOTS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl_w),
    .stat_o            (stat_w),
    .command_i         (command_i),
    .sender_id_i       (sender_id_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .receiver_id_out_o (receiver_id_out_o),
    .sender_count_o    (sender_count_o),
    .reported_sender_o (reported_sender_o),
    .last_o            (last_o)
  );

endmodule

/* hw/rtl/hbss_chk.sv */
module hbss_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   status_o,
  input logic [hbss_pkg::IdW-1:0]     reported_sender_o,
  input logic [hbss_pkg::CntOutW-1:0] sender_count_o,
  input logic                         last_o
);
  import hbss_pkg::*;

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reported_sender_o)
      && $stable(last_o))
    else $error("stalled output word changed");

  // One word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // Error status only on a single closing word
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o && (reported_sender_o == '0))
    else $error("error word not final or carries a sender");

  // Heartbeat words with senders carry ok status
  a_hb_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sender_count_o != '0) |-> (status_o == ST_OK))
    else $error("heartbeat word with bad status");

endmodule

bind heartbeat_sender_set_engine hbss_chk u_hbss_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .reported_sender_o (reported_sender_o),
  .sender_count_o    (sender_count_o),
  .last_o            (last_o)
);

/* sim/tb_heartbeat_sender_set_engine.sv */
module tb_heartbeat_sender_set_engine;
  import hbss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = 128;
  localparam int unsigned LoadLimit = Slots / 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rid;
    logic [6:0]  cnt;
    logic [31:0] snd;
    logic        last;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CMD_NOP;
  logic [31:0] sender_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] receiver_id_out_o;
  logic [6:0]  sender_count_o;
  logic [31:0] reported_sender_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  heartbeat_sender_set_engine dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copies of the two id tables and the receiver id
  logic [31:0] sched_tbl [Slots];
  logic [31:0] blk_tbl [Slots];
  int unsigned sched_cnt, blk_cnt;
  logic [31:0] rcv_id;
  word_t       expected_words [$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned mismatches;
  logic [31:0] pool [16];

  function automatic bit tbl_has(bit blk, logic [31:0] id);
    int unsigned i;
    logic [31:0] e;
    i = id % Slots;
    for (int n = 0; n < Slots; n++) begin
      e = blk ? blk_tbl[i] : sched_tbl[i];
      if (e == 0) return 0;
      if (e == id) return 1;
      i = (i + 1) % Slots;
    end
    return 0;
  endfunction

  function automatic void tbl_place(bit blk, logic [31:0] id);
    int unsigned i;
    logic [31:0] e;
    i = id % Slots;
    for (int n = 0; n < Slots; n++) begin
      e = blk ? blk_tbl[i] : sched_tbl[i];
      if (e == 0) begin
        if (blk) begin
          blk_tbl[i] = id;
          blk_cnt++;
        end else begin
          sched_tbl[i] = id;
          sched_cnt++;
        end
        return;
      end
      if (e == id) return;
      i = (i + 1) % Slots;
    end
  endfunction

  // Remove an id from the scheduled table, then re-seat the rest of its cluster
  function automatic void sched_drop(logic [31:0] id);
    int unsigned i, j;
    logic [31:0] moved;
    i = id % Slots;
    for (int n = 0; n < Slots; n++) begin
      if (sched_tbl[i] == 0) return;
      if (sched_tbl[i] == id) begin
        sched_tbl[i] = 0;
        if (sched_cnt > 0) sched_cnt--;
        j = (i + 1) % Slots;
        for (int m = 0; m < Slots && sched_tbl[j] != 0; m++) begin
          moved = sched_tbl[j];
          sched_tbl[j] = 0;
          if (sched_cnt > 0) sched_cnt--;
          tbl_place(0, moved);
          j = (j + 1) % Slots;
        end
        return;
      end
      i = (i + 1) % Slots;
    end
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < Slots; i++) begin
      sched_tbl[i] = 0;
      blk_tbl[i] = 0;
    end
    sched_cnt = 0;
    blk_cnt = 0;
  endfunction

  // Work out the words one command produces
  function automatic void predict_words(cmd_e cmd, logic [31:0] id);
    word_t w;
    logic [31:0] ids [$];
    w = '0;
    w.last = 1'b1;
    case (cmd)
      CMD_SCHED: begin
        if (id == 0) w.status = ST_ZERO_ID;
        else if (!tbl_has(1, id)) begin
          if (sched_cnt >= LoadLimit) w.status = ST_SCHED_FULL;
          else tbl_place(0, id);
        end
        expected_words.push_back(w);
      end
      CMD_DESCHED: begin
        if (id == 0) w.status = ST_ZERO_ID;
        else begin
          sched_drop(id);
          if (blk_cnt >= LoadLimit) w.status = ST_BLK_FULL;
          else tbl_place(1, id);
        end
        expected_words.push_back(w);
      end
      CMD_TICK: begin
        for (int i = 0; i < Slots; i++)
          if (sched_tbl[i] != 0 && ids.size() < 64) ids.push_back(sched_tbl[i]);
        clear_tables();
        w.rid = rcv_id;
        if (ids.size() == 0) expected_words.push_back(w);
        else begin
          foreach (ids[k]) begin
            w.cnt = 7'(ids.size());
            w.snd = ids[k];
            w.last = (k == ids.size() - 1);
            expected_words.push_back(w);
          end
        end
      end
      default: expected_words.push_back(w);
    endcase
  endfunction

  // Send one command word, idling first at random; valid stays up until
  // the next idle cycle or the drain
  task automatic send_cmd(cmd_e cmd, logic [31:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    sender_id_i <= id;
    predict_words(cmd, id);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Receiver stall and result checking
  always @(posedge clk_i) begin
    word_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{status_o, receiver_id_out_o, sender_count_o, reported_sender_o, last_o};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp st=%0d rid=%h cnt=%0d snd=%h last=%0b",
                       want.status, want.rid, want.cnt, want.snd, want.last);
              $display("          got st=%0d rid=%h cnt=%0d snd=%h last=%0b",
                       got.status, got.rid, got.cnt, got.snd, got.last);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_receiver_id(logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    rcv_id = v;
  endtask

  function automatic logic [31:0] pick_id();
    case ($urandom_range(3))
      0: return pool[$urandom_range(15)];
      1: return $urandom_range(255);
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    write_receiver_id(32'hFFFF_FFFF);
    send_cmd(CMD_TICK, 32'h0);
    send_cmd(CMD_SCHED, 32'h0);
    send_cmd(CMD_DESCHED, 32'h0);
    send_cmd(CMD_SCHED, 32'hFFFF_FFFF);
    send_cmd(CMD_SCHED, 32'h0000_007F);
    send_cmd(CMD_SCHED, 32'h0000_00FF);
    send_cmd(CMD_SCHED, 32'h0000_00FF);
    send_cmd(CMD_SCHED, 32'h0000_0080);
    send_cmd(CMD_SCHED, 32'h0000_0001);
    // removal from the middle of a wrapped cluster
    send_cmd(CMD_DESCHED, 32'h0000_007F);
    send_cmd(CMD_SCHED, 32'h0000_007F);
    send_cmd(CMD_DESCHED, 32'h1234_5678);
    send_cmd(CMD_NOP, 32'hAAAA_5555);
    send_cmd(CMD_TICK, 32'h5555_AAAA);
    drain();
  endtask

  // Fill both tables to the load limit and push past it
  task automatic test_full_tables();
    write_receiver_id(32'h0);
    for (int i = 1; i <= LoadLimit + 1; i++) send_cmd(CMD_SCHED, i * 3);
    send_cmd(CMD_SCHED, 32'd3);
    for (int i = 1; i <= LoadLimit + 1; i++) send_cmd(CMD_DESCHED, 32'h8000_0000 + i);
    send_cmd(CMD_DESCHED, 32'd6);
    send_cmd(CMD_TICK, 32'h0);
    drain();
  endtask

  task automatic test_random(int unsigned n);
    int unsigned r;
    for (int i = 0; i < 16; i++) pool[i] = $urandom_range(1, 600);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) send_cmd(CMD_SCHED, pick_id());
      else if (r < 85) send_cmd(CMD_DESCHED, pick_id());
      else if (r < 96) send_cmd(CMD_TICK, $urandom);
      else send_cmd(CMD_NOP, $urandom);
    end
    drain();
  endtask

  initial begin
    clear_tables();
    rcv_id = 0;
    mismatches = 0;
    send_idle_pct = 34;
    recv_idle_pct = 51;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_tables();
    test_random(10);
    send_idle_pct = 51;
    recv_idle_pct = 34;
    write_receiver_id($urandom);
    test_random(10);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_receiver_id(32'h8000_0001);
    test_random(10);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("tb_heartbeat_sender_set_engine: PASS");
    else
      $display("tb_heartbeat_sender_set_engine: FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("tb_heartbeat_sender_set_engine: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/hbss_pkg.sv
hw/rtl/hbss_mod.sv
hw/rtl/hbss_dp.sv
hw/rtl/hbss_ctrl.sv
hw/rtl/heartbeat_sender_set_engine.sv
hw/rtl/hbss_chk.sv
sim/tb_heartbeat_sender_set_engine.sv
